// ===== rtl/core/lskl_pkg.sv =====
// Shared types, constants and codes for the lookahead soft-knee limiter.
`default_nettype none
package lskl_pkg;

   localparam int DELAY_SAMPLES_DEF = 240;
   localparam int MAX_CHANNELS_DEF  = 2;
   localparam int HOLD_FACTOR       = 5;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;
   localparam int FACTOR_W = 24;
   localparam int COEF_W   = 16;
   localparam int CLIP_W   = 23;
   localparam int CHCNT_W  = 2;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W   = 48;
   localparam int DIV_N    = 48;
   localparam int DEN_W    = 25;
   localparam int REQ_W    = 72;
   localparam int RSP_W    = 64;

   localparam logic [23:0] THR_CAP       = 24'hFFFFFF;
   localparam logic [23:0] KNEE_LOW_Q16  = 24'd45871;
   localparam logic [23:0] KNEE_DROP_Q15 = 24'd9830;
   localparam logic [15:0] UNITY_Q15     = 16'd32768;
   // ceil(10 * 2^27 / 7) split at bit 14; exact for any 24-bit threshold.
   localparam logic [23:0] HI_MUL_HI     = 24'd11702;
   localparam logic [23:0] HI_MUL_LO     = 24'd14044;

   localparam logic [22:0] CLIP_RST    = 23'd8388607;
   localparam logic [23:0] SCALE_RST   = 24'd39322;
   localparam logic [23:0] ADJUST_RST  = 24'd65536;
   localparam logic [23:0] HEADRM_RST  = 24'd65536;
   localparam logic [15:0] REL_RST     = 16'd655;
   localparam logic [15:0] ATT_RST     = 16'd16384;
   localparam logic [23:0] FLOOR_RST   = 24'd1;
   localparam logic [1:0]  CHCNT_RST   = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_LEVEL   = 3'd0,
      CSR_AERL_SCALE   = 3'd1,
      CSR_THR_ADJUST   = 3'd2,
      CSR_CLIP_HEADRM  = 3'd3,
      CSR_RELEASE_COEF = 3'd4,
      CSR_ATTACK_COEF  = 3'd5,
      CSR_AERL_FLOOR   = 3'd6,
      CSR_CHANNEL_CNT  = 3'd7
   } csr_idx_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_PEAK, OP_ENV_M1, OP_ENV_M2, OP_ENV_UPD,
      OP_TC1, OP_TC_M2, OP_TC2_DIV, OP_THR, OP_LO_M, OP_LO, OP_HI_M2, OP_HI,
      OP_DIV_TGT, OP_TGT_Q, OP_KNEE_M, OP_DIV_KNEE, OP_TGT_K, OP_TGT_U,
      OP_SM_M, OP_SMOOTH, OP_O0_M, OP_O0, OP_O1_M, OP_O1, OP_FINISH
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_PEAK, ST_ENV_M1, ST_ENV_M2, ST_ENV_UPD, ST_TC1,
      ST_TC_M2, ST_TC2, ST_DIV_TA, ST_THR, ST_LO_M, ST_LO, ST_HI_M2,
      ST_HI, ST_DECIDE, ST_DIV_TGT, ST_TGT_Q, ST_KNEE_DS,
      ST_DIV_KNEE, ST_TGT_K, ST_SM_M, ST_SMOOTH, ST_O0_M, ST_O0, ST_O1_M,
      ST_O1, ST_FINISH
   } st_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_busy;
      logic env_gt_hi;
      logic env_gt_lo;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/lskl_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lskl_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lskl_pkg::DIV_N-1:0]  dividend,
   input  wire logic [lskl_pkg::DEN_W-1:0]  divisor,
   output      logic                        busy,
   output      logic [lskl_pkg::DIV_N-1:0]  quotient
);
   import lskl_pkg::*;

   localparam int CNT_W = $clog2(DIV_N + 1);

   logic [DIV_N-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, num_ff[DIV_N-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIV_N);
         num_ff  <= dividend;
         rem_ff  <= '0;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_ff  <= {num_ff[DIV_N-2:0], fits};
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= cnt_ff != CNT_W'(1);
      end
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;
endmodule
`default_nettype wire

// ===== rtl/core/lskl_ctrl.sv =====
// Sequencer for the limiter: steps the datapath through one sample.
`default_nettype none
module lskl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire lskl_pkg::status_type   status,
   output      lskl_pkg::cmd_type      cmd
);
   import lskl_pkg::*;

   st_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_PEAK;
            end
         end
         ST_PEAK:    begin cmd.op = OP_PEAK;    state_in = ST_ENV_M1;  end
         ST_ENV_M1:  begin cmd.op = OP_ENV_M1;  state_in = ST_ENV_M2;  end
         ST_ENV_M2:  begin cmd.op = OP_ENV_M2;  state_in = ST_ENV_UPD; end
         ST_ENV_UPD: begin cmd.op = OP_ENV_UPD; state_in = ST_TC1;     end
         ST_TC1:     begin cmd.op = OP_TC1;     state_in = ST_TC_M2;   end
         ST_TC_M2:   begin cmd.op = OP_TC_M2;   state_in = ST_TC2;     end
         ST_TC2:     begin cmd.op = OP_TC2_DIV; state_in = ST_DIV_TA;  end
         ST_DIV_TA: begin
            if (!status.div_busy) state_in = ST_THR;
         end
         ST_THR:     begin cmd.op = OP_THR;     state_in = ST_LO_M;    end
         ST_LO_M:    begin cmd.op = OP_LO_M;    state_in = ST_LO;      end
         ST_LO:      begin cmd.op = OP_LO;      state_in = ST_HI_M2;   end
         ST_HI_M2:   begin cmd.op = OP_HI_M2;   state_in = ST_HI;      end
         ST_HI:      begin cmd.op = OP_HI;      state_in = ST_DECIDE;  end
         ST_DECIDE: begin
            priority if (status.env_gt_hi) begin
               cmd.op   = OP_DIV_TGT;
               state_in = ST_DIV_TGT;
            end else if (status.env_gt_lo) begin
               cmd.op   = OP_KNEE_M;
               state_in = ST_KNEE_DS;
            end else begin
               cmd.op   = OP_TGT_U;
               state_in = ST_SM_M;
            end
         end
         ST_DIV_TGT: begin
            if (!status.div_busy) state_in = ST_TGT_Q;
         end
         ST_TGT_Q:   begin cmd.op = OP_TGT_Q;    state_in = ST_SM_M;     end
         ST_KNEE_DS: begin cmd.op = OP_DIV_KNEE; state_in = ST_DIV_KNEE; end
         ST_DIV_KNEE: begin
            if (!status.div_busy) state_in = ST_TGT_K;
         end
         ST_TGT_K:   begin cmd.op = OP_TGT_K;   state_in = ST_SM_M;    end
         ST_SM_M:    begin cmd.op = OP_SM_M;    state_in = ST_SMOOTH;  end
         ST_SMOOTH:  begin cmd.op = OP_SMOOTH;  state_in = ST_O0_M;    end
         ST_O0_M:    begin cmd.op = OP_O0_M;    state_in = ST_O0;      end
         ST_O0:      begin cmd.op = OP_O0;      state_in = ST_O1_M;    end
         ST_O1_M:    begin cmd.op = OP_O1_M;    state_in = ST_O1;      end
         ST_O1:      begin cmd.op = OP_O1;      state_in = ST_FINISH;  end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/lskl_dp.sv =====
// Limiter datapath: registers, delay memories, shared multiplier and divider.
`default_nettype none
module lskl_dp #(
   parameter int DELAY_SAMPLES = lskl_pkg::DELAY_SAMPLES_DEF,
   parameter int MAX_CHANNELS  = lskl_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lskl_pkg::cmd_type              cmd,
   output      lskl_pkg::status_type           status,
   input  wire logic [lskl_pkg::REQ_W-1:0]     req_tdata,
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [lskl_pkg::RSP_W-1:0]     rsp_tdata,
   input  wire logic                           csr_we,
   input  wire logic [lskl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lskl_pkg::CSR_W-1:0]     csr_wdata
);
   import lskl_pkg::*;

   localparam int AW     = (DELAY_SAMPLES > 1) ? $clog2(DELAY_SAMPLES) : 1;
   localparam int HOLD_N = HOLD_FACTOR * DELAY_SAMPLES;
   localparam int HOLD_W = $clog2(HOLD_N + 1);

   // configuration
   logic [CLIP_W-1:0]   clip_ff;
   logic [FACTOR_W-1:0] scale_ff, adjust_ff, headrm_ff, floor_ff;
   logic [COEF_W-1:0]   rel_ff, att_ff;
   logic [CHCNT_W-1:0]  chcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff   <= CLIP_RST;
         scale_ff  <= SCALE_RST;
         adjust_ff <= ADJUST_RST;
         headrm_ff <= HEADRM_RST;
         rel_ff    <= REL_RST;
         att_ff    <= ATT_RST;
         floor_ff  <= FLOOR_RST;
         chcnt_ff  <= CHCNT_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_CLIP_LEVEL:   clip_ff   <= csr_wdata[CLIP_W-1:0];
            CSR_AERL_SCALE:   scale_ff  <= csr_wdata;
            CSR_THR_ADJUST:   adjust_ff <= csr_wdata;
            CSR_CLIP_HEADRM:  headrm_ff <= csr_wdata;
            CSR_RELEASE_COEF: rel_ff    <= csr_wdata[COEF_W-1:0];
            CSR_ATTACK_COEF:  att_ff    <= csr_wdata[COEF_W-1:0];
            CSR_AERL_FLOOR:   floor_ff  <= csr_wdata;
            CSR_CHANNEL_CNT:  chcnt_ff  <= csr_wdata[CHCNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic stereo;
   assign stereo = (MAX_CHANNELS >= 2) && chcnt_ff[1];

   // working registers
   logic signed [SAMPLE_W-1:0] x0_ff, x1_ff, d0_ff, d1_ff, o0_ff, o1_ff;
   logic [FACTOR_W-1:0] ainv_ff;
   logic [23:0]         peak_ff, env_ff, tc_ff, thr_ff, lo_ff;
   logic [24:0]         hi_ff;
   logic [HOLD_W-1:0]   hold_ff;
   logic [GAIN_W-1:0]   gain_ff, target_ff;
   logic [PROD_W-1:0]   prod_ff, acc_ff;
   logic [AW-1:0]       pos_ff;
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff;

   // delay memories
   logic signed [SAMPLE_W-1:0] mem0 [DELAY_SAMPLES];
   logic signed [SAMPLE_W-1:0] rd0, rd1;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLEAR) mem0[pos_ff] <= '0;
      else if (cmd.op == OP_PEAK) mem0[pos_ff] <= x0_ff;
      if (cmd.op == OP_PEAK) rd0 <= mem0[pos_ff];
   end

   if (MAX_CHANNELS >= 2) begin : g_ch1
      logic signed [SAMPLE_W-1:0] mem1 [DELAY_SAMPLES];
      always_ff @(posedge clock) begin
         if (cmd.op == OP_CLEAR) mem1[pos_ff] <= '0;
         else if (cmd.op == OP_PEAK && stereo) mem1[pos_ff] <= x1_ff;
         if (cmd.op == OP_PEAK) rd1 <= mem1[pos_ff];
      end
   end else begin : g_mono
      assign rd1 = '0;
   end

   // magnitudes
   function automatic logic [23:0] mag(input logic signed [23:0] v);
      mag = v[23] ? 24'(-v) : 24'(v);
   endfunction

   logic [23:0] m0, m1, peak_now;
   assign m0 = mag(x0_ff);
   assign m1 = mag(x1_ff);
   assign peak_now = (stereo && m1 > m0) ? m1 : m0;

   // shared multiplier
   logic [23:0] mul_a, mul_b;
   logic        mul_en;
   logic        rising;
   logic [15:0] diff;
   assign rising = target_ff > gain_ff;
   assign diff   = rising ? 16'(target_ff - gain_ff) : 16'(gain_ff - target_ff);

   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (cmd.op)
         OP_ENV_M1:  begin mul_a = env_ff;  mul_b = 24'(17'h10000 - {1'b0, rel_ff}); end
         OP_ENV_M2:  begin mul_a = peak_ff; mul_b = 24'(rel_ff); end
         OP_ENV_UPD: begin mul_a = 24'(clip_ff); mul_b = adjust_ff; end
         OP_TC_M2:   begin mul_a = tc_ff;   mul_b = headrm_ff; end
         OP_LO_M:    begin mul_a = thr_ff;  mul_b = KNEE_LOW_Q16; end
         OP_LO:      begin mul_a = thr_ff;  mul_b = HI_MUL_HI; end
         OP_HI_M2:   begin mul_a = thr_ff;  mul_b = HI_MUL_LO; end
         OP_KNEE_M:  begin mul_a = 24'(env_ff - lo_ff); mul_b = KNEE_DROP_Q15; end
         OP_SM_M:    begin mul_a = 24'(diff); mul_b = 24'(rising ? rel_ff : att_ff); end
         OP_O0_M:    begin mul_a = mag(d0_ff); mul_b = 24'(gain_ff); end
         OP_O1_M:    begin mul_a = mag(d1_ff); mul_b = 24'(gain_ff); end
         default:    mul_en = 1'b0;
      endcase
   end

   // divider
   logic              div_start;
   logic [DIV_N-1:0]  div_num, div_q;
   logic [DEN_W-1:0]  div_den;
   logic              div_busy;
   logic [23:0]       den_ta;

   assign den_ta = (ainv_ff > floor_ff) ? ainv_ff :
                   (floor_ff == '0 ? 24'd1 : floor_ff);

   always_comb begin
      div_start = 1'b1;
      div_num   = '0;
      div_den   = '0;
      unique case (cmd.op)
         OP_TC2_DIV:  begin div_num = {1'b0, scale_ff, 23'd0}; div_den = 25'(den_ta); end
         OP_DIV_TGT:  begin div_num = {9'd0, thr_ff, 15'd0}; div_den = 25'(env_ff); end
         OP_DIV_KNEE: begin div_num = prod_ff; div_den = hi_ff - 25'(lo_ff); end
         default:     div_start = 1'b0;
      endcase
   end

   lskl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // saturating helpers
   function automatic logic [23:0] sat_hi(input logic [PROD_W-1:0] p);
      sat_hi = (p[47:40] != '0) ? THR_CAP : p[39:16];
   endfunction

   logic [23:0] ta;
   assign ta = (div_q[47:24] != '0) ? THR_CAP : div_q[23:0];

   logic [PROD_W-1:0] env_sum;
   assign env_sum = acc_ff + prod_ff;

   // Upper knee edge, thr * 10 / 7, as thr times the reciprocal constant over 2^27.
   logic [PROD_W+13:0] hi_sum;
   assign hi_sum = {acc_ff, 14'd0} + {14'd0, prod_ff};

   logic [15:0] sm_step;
   assign sm_step = 16'((prod_ff + 48'd65535) >> 16);

   // gained and clipped sample from the product of magnitude and gain
   function automatic logic signed [23:0] shape(input logic neg,
                                               input logic [PROD_W-1:0] p,
                                               input logic [CLIP_W-1:0] lim);
      logic [PROD_W-1:0] q;
      logic [23:0]       qc;
      q  = neg ? ((p + 48'd32767) >> 15) : (p >> 15);
      qc = (q > PROD_W'(lim)) ? 24'(lim) : q[23:0];
      shape = neg ? 24'(-qc) : 24'(qc);
   endfunction

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= mul_a * mul_b;
      unique case (cmd.op)
         OP_LOAD: begin
            x0_ff   <= req_tdata[23:0];
            x1_ff   <= req_tdata[47:24];
            ainv_ff <= req_tdata[71:48];
         end
         OP_PEAK: begin
            peak_ff <= peak_now;
            d0_ff   <= '0;
         end
         OP_ENV_M1: begin
            d0_ff <= rd0;
            d1_ff <= stereo ? rd1 : '0;
         end
         OP_ENV_M2:  acc_ff <= prod_ff;
         OP_TC1:     tc_ff  <= sat_hi(prod_ff);
         OP_TC2_DIV: tc_ff  <= sat_hi(prod_ff);
         OP_THR:     thr_ff <= (ta < tc_ff) ? ta : tc_ff;
         OP_LO:      lo_ff  <= prod_ff[39:16];
         OP_HI_M2:   acc_ff <= prod_ff;
         OP_HI:      hi_ff  <= hi_sum[51:27];
         OP_TGT_Q:   target_ff <= div_q[15:0];
         OP_TGT_K:   target_ff <= 16'(UNITY_Q15 - div_q[15:0]);
         OP_TGT_U:   target_ff <= UNITY_Q15;
         OP_O0:      o0_ff <= shape(d0_ff[23], prod_ff, clip_ff);
         OP_O1:      o1_ff <= stereo ? shape(d1_ff[23], prod_ff, clip_ff) : '0;
         default: ;
      endcase
   end

   // state that reset must set
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff       <= '0;
         hold_ff      <= '0;
         gain_ff      <= UNITY_Q15;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_ENV_UPD) begin
            priority if (peak_ff > env_ff) begin
               env_ff  <= peak_ff;
               hold_ff <= HOLD_W'(HOLD_N);
            end else if (hold_ff == '0) begin
               env_ff <= env_sum[39:16];
            end else begin
               hold_ff <= hold_ff - 1'b1;
            end
         end
         if (cmd.op == OP_SMOOTH)
            gain_ff <= rising ? 16'(gain_ff + sm_step) : 16'(gain_ff - sm_step);
         if (cmd.op == OP_CLEAR || cmd.op == OP_FINISH)
            pos_ff <= (pos_ff == AW'(DELAY_SAMPLES - 1)) ? '0 : pos_ff + 1'b1;
         if (cmd.op == OP_FINISH) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)     rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_FINISH) rsp_data_ff <= {gain_ff, o1_ff, o0_ff};
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign status.clr_last  = pos_ff == AW'(DELAY_SAMPLES - 1);
   assign status.div_busy  = div_busy;
   assign status.env_gt_hi = {1'b0, env_ff} > hi_ff;
   assign status.env_gt_lo = env_ff > lo_ff;
   assign status.out_free  = out_free;
endmodule
`default_nettype wire

// ===== rtl/core/lookahead_soft_knee_limiter_top.sv =====
// Top level of the lookahead soft-knee peak limiter.
// The 48-step divider runs once per sample below the knee and twice within or
// above it. One sample is in work at a time: no new input beat is taken until
// the result of the last has been loaded into the output register.
// Reset: synchronous; afterwards the delay memories are swept to zero, and no
// input beat is taken until the sweep is done.
`default_nettype none
module lookahead_soft_knee_limiter_top #(
   parameter int DELAY_SAMPLES = lskl_pkg::DELAY_SAMPLES_DEF,
   parameter int MAX_CHANNELS  = lskl_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata: sample_ch0 [23:0], sample_ch1 [47:24], aerl_inverse [71:48]
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [lskl_pkg::REQ_W-1:0]     req_tdata,
   // rsp_tdata: out_ch0 [23:0], out_ch1 [47:24], gain_out [63:48]
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [lskl_pkg::RSP_W-1:0]     rsp_tdata,
   input  wire logic                           csr_we,
   input  wire logic [lskl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lskl_pkg::CSR_W-1:0]     csr_wdata
);
   import lskl_pkg::*;

   // The sequencer issues one command per cycle; the datapath answers with
   // the five status flags that steer the sequence (end of the clear sweep, divider
   // busy, which knee region the envelope is in, whether the output register is free).
   cmd_type    cmd;
   status_type status;

   lskl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the configuration, the envelope and gain state, the
   // delay memories (one per channel, two at most) and the one multiplier and
   // one divider that all the multiplications and divisions of a sample share.
   lskl_dp #(
      .DELAY_SAMPLES (DELAY_SAMPLES),
      .MAX_CHANNELS  (MAX_CHANNELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );
endmodule
`default_nettype wire

// ===== rtl/core/lskl_check.sv =====
// Port-level checker for the limiter, bound to the top level.
`default_nettype none
module lskl_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:48] <= 16'd32768)
      else $error("gain above unity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input beat taken while a sample is in work");
endmodule

bind lookahead_soft_knee_limiter_top lskl_check u_lskl_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== tb/sv/tb_lookahead_soft_knee_limiter_top.sv =====
// Self-checking testbench for the lookahead soft-knee limiter top level.
`default_nettype none
module tb_lookahead_soft_knee_limiter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lskl_pkg::*;

   localparam int DELAY   = 240;
   localparam int N_PHASE = 8;
   localparam int PHASE_N = 230;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // Fields from the lowest bit up: sample_ch0, sample_ch1, aerl_inverse.
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // Fields from the lowest bit up: out_ch0, out_ch1, gain_out.
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // While this is set neither side idles, so the block is offered a new beat as soon as it can take one.
   bit no_gaps = 1'b0;

   always #2 clock = ~clock;

   lookahead_soft_knee_limiter_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Limiter predictor and the queue of the output beats it expects.
   class limiter_scoreboard;
      longint unsigned clip, scale, adjust, headroom, rel, att, inv_floor, chans;
      longint unsigned envelope, hold, gain;
      logic signed [23:0] line0 [DELAY];
      logic signed [23:0] line1 [DELAY];
      int unsigned wr_pos;
      logic [RSP_W-1:0] pending [$];
      int errors;

      function new();
         clip = CLIP_RST; scale = SCALE_RST; adjust = ADJUST_RST;
         headroom = HEADRM_RST; rel = REL_RST; att = ATT_RST;
         inv_floor = FLOOR_RST; chans = CHCNT_RST;
         envelope = 0; hold = 0; gain = UNITY_Q15; wr_pos = 0; errors = 0;
         foreach (line0[i]) begin
            line0[i] = '0;
            line1[i] = '0;
         end
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_W-1:0] v);
         case (idx)
            CSR_CLIP_LEVEL:   clip = v[22:0];
            CSR_AERL_SCALE:   scale = v;
            CSR_THR_ADJUST:   adjust = v;
            CSR_CLIP_HEADRM:  headroom = v;
            CSR_RELEASE_COEF: rel = v[15:0];
            CSR_ATTACK_COEF:  att = v[15:0];
            CSR_AERL_FLOOR:   inv_floor = v;
            CSR_CHANNEL_CNT:  chans = v[1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned magnitude(logic signed [23:0] v);
         longint s;
         s = v;
         return s < 0 ? -s : s;
      endfunction

      // Gain is applied with rounding towards minus infinity, then clipped.
      function logic [23:0] scaled(logic signed [23:0] x);
         longint p, q, lim;
         p = longint'(x) * longint'(gain);
         lim = clip;
         if (p >= 0) q = p >>> 15;
         else q = -((-p + 32767) >>> 15);
         if (q > lim) q = lim;
         if (q < -lim) q = -lim;
         return q[23:0];
      endfunction

      function void note_input(logic [REQ_W-1:0] d);
         logic signed [23:0] x0, x1, d0, d1;
         longint unsigned ainv, peak, den, ta, tc, thr, lo, hi, target, diff;
         logic [23:0] o0, o1;
         bit stereo;
         x0 = d[23:0];
         x1 = d[47:24];
         ainv = d[71:48];
         stereo = chans >= 2;
         peak = magnitude(x0);
         if (stereo && magnitude(x1) > peak) peak = magnitude(x1);

         if (peak > envelope) begin
            envelope = peak;
            hold = (5 * DELAY) & 13'h1FFF;
         end else if (hold == 0) begin
            envelope = ((envelope * (65536 - rel) + peak * rel) >> 16) & 24'hFFFFFF;
         end else begin
            hold = hold - 1;
         end

         den = ainv > inv_floor ? ainv : inv_floor;
         if (den == 0) den = 1;
         ta = (scale << 23) / den;
         if (ta > 24'hFFFFFF) ta = 24'hFFFFFF;
         tc = (clip * adjust) >> 16;
         if (tc > 24'hFFFFFF) tc = 24'hFFFFFF;
         tc = (tc * headroom) >> 16;
         if (tc > 24'hFFFFFF) tc = 24'hFFFFFF;
         thr = ta < tc ? ta : tc;

         // Knee: hard above 10/7 of the threshold, linear from 0.7 of it.
         lo = (thr * 45871) >> 16;
         hi = (thr * 10) / 7;
         if (envelope > hi) target = (thr << 15) / envelope;
         else if (envelope > lo) target = 32768 - (9830 * (envelope - lo)) / (hi - lo);
         else target = 32768;

         if (target > gain) begin
            diff = (target - gain) * rel;
            gain = gain + ((diff + 65535) >> 16);
         end else begin
            diff = (gain - target) * att;
            gain = gain - ((diff + 65535) >> 16);
         end

         d0 = line0[wr_pos];
         line0[wr_pos] = x0;
         o0 = scaled(d0);
         if (stereo) begin
            d1 = line1[wr_pos];
            line1[wr_pos] = x1;
            o1 = scaled(d1);
         end else begin
            o1 = '0;
         end
         wr_pos = (wr_pos + 1) % DELAY;
         pending.push_back({gain[15:0], o1, o0});
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [RSP_W-1:0] got);
         logic [RSP_W-1:0] want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected output beat %h", got));
            return;
         end
         want = pending.pop_front();
         if (got[23:0] !== want[23:0])
            report($sformatf("out_ch0 got %h want %h", got[23:0], want[23:0]));
         if (got[47:24] !== want[47:24])
            report($sformatf("out_ch1 got %h want %h", got[47:24], want[47:24]));
         if (got[63:48] !== want[63:48])
            report($sformatf("gain_out got %h want %h", got[63:48], want[63:48]));
      endtask
   endclass

   limiter_scoreboard limiter_sb = new();

   function bit take_gap();
      return !no_gaps && ($urandom_range(99) < 9);
   endfunction

   // Result side: check each accepted beat, then stall at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) limiter_sb.check_result(rsp_tdata);
         rsp_tready <= !take_gap();
      end
   end

   // Registers are written back to back, one per cycle, while the block is idle.
   task write_settings(logic [CSR_W-1:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= csr_idx_type'(i);
         csr_wdata <= vals[i];
         limiter_sb.set_reg(csr_idx_type'(i), vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Waits until every expected beat has come back, plus a short margin.
   task drain();
      while (limiter_sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task send_sample(logic signed [23:0] x0, logic signed [23:0] x1, logic [23:0] ainv);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ainv, x1, x0};
      do @(posedge clock); while (!req_tready);
      limiter_sb.note_input({ainv, x1, x0});
   endtask

   task send_directed();
      send_sample(24'sh800000, 24'sh7FFFFF, 24'd0);
      send_sample(24'sh7FFFFF, 24'sh800000, 24'hFFFFFF);
      send_sample(24'sh000000, 24'shFFFFFF, 24'd1);
      send_sample(24'shFFFFFF, 24'sh000000, 24'd65536);
      send_sample(24'sh555555, 24'shAAAAAA, 24'hAAAAAA);
      send_sample(24'shAAAAAA, 24'sh555555, 24'h555555);
      send_sample(24'sh000001, 24'sh800000, 24'd2);
      send_sample(24'sh400000, 24'sh3FFFFF, 24'd100);
      send_sample(24'sh000000, 24'sh000000, 24'd0);
      send_sample(24'shC00000, 24'sh7FFFFF, 24'd39322);
      req_tvalid <= 1'b0;
   endtask

   // Random sample whose amplitude is set by a shift, with rare full-scale values.
   function logic signed [23:0] rand_sample(int shift);
      logic signed [23:0] v;
      v = 24'($urandom());
      if ($urandom_range(99) < 3) return $urandom_range(1) ? 24'sh800000 : 24'sh7FFFFF;
      return v >>> shift;
   endfunction

   logic [CSR_W-1:0] regs [8];
   int amp_shift;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: mono, then the same corners in stereo with a zero floor.
      send_directed();
      drain();
      regs = '{24'h7FFFFF, 24'd39322, 24'd65536, 24'd65536, 24'd655, 24'd16384,
               24'd0, 24'd2};
      write_settings(regs);
      send_directed();
      drain();

      for (int ph = 0; ph < N_PHASE; ph++) begin
         if (ph == 0) begin
            // Everything at its lowest: zero threshold, frozen smoothing.
            regs = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
         end else if (ph == 1) begin
            regs = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF,
                     24'hFFFF, 24'hFFFFFF, 24'd3};
         end else begin
            regs[0] = CSR_W'($urandom_range(24'hFFFFFF, 24'h100000));
            regs[1] = CSR_W'($urandom_range(200000, 1000));
            regs[2] = CSR_W'($urandom_range(131072, 32768));
            regs[3] = CSR_W'($urandom_range(131072, 32768));
            regs[4] = CSR_W'($urandom_range(8000, 1));
            regs[5] = CSR_W'($urandom_range(65535, 1000));
            regs[6] = CSR_W'($urandom_range(70000, 1));
            regs[7] = CSR_W'($urandom_range(3));
         end
         write_settings(regs);
         no_gaps = (ph == 5);
         amp_shift = 0;
         for (int n = 0; n < PHASE_N; n++) begin
            if (n % 64 == 0) amp_shift = $urandom_range(12);
            send_sample(rand_sample(amp_shift), rand_sample(amp_shift),
                        ($urandom_range(99) < 20) ? 24'($urandom())
                                                   : 24'($urandom_range(200000, 1)));
         end
         req_tvalid <= 1'b0;
         no_gaps = 1'b0;
         drain();
      end

      repeat (200) @(posedge clock);
      if (limiter_sb.pending.size() != 0)
         limiter_sb.report($sformatf("%0d output beats never arrived",
                                     limiter_sb.pending.size()));
      if (limiter_sb.errors == 0)
         $display("[lookahead_soft_knee_limiter_top] OK");
      else
         $display("[lookahead_soft_knee_limiter_top] ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("[lookahead_soft_knee_limiter_top] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
